[rtl/rws_pkg.sv]
// Shared types and constants for the roulette wheel selector.
// Holds the transaction structs, command codes and controller/datapath links.
// No dependencies.
package rws_pkg;

    // Table and field sizes
    localparam int POP_MAX = 64;
    localparam int IDX_W   = $clog2(POP_MAX);
    localparam int CNT_W   = $clog2(POP_MAX + 1);
    localparam int FIT_W   = 32;
    localparam int SUM_W   = FIT_W + IDX_W;
    localparam int DRAW_W  = 10;
    localparam int PROD_W  = SUM_W + DRAW_W;

    // Scale of the random draw (thousandths)
    localparam logic [DRAW_W-1:0] SCALE = DRAW_W'(1000);

    // Command codes; code 3 is unused and ignored
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_DRAW  = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [FIT_W-1:0]  fitness_value;
        logic [DRAW_W-1:0] random_draw;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0] selected_index;
        logic             empty_flag;
    } result_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOOP,
        ST_READ,
        ST_MULT,
        ST_STEP,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic capture;
        logic setup;
        logic read;
        logic mult;
        logic step;
        logic emit;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic done;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/rws_datapath.sv]
// Datapath of the roulette wheel selector: cumulative-sum memory, totals,
// binary-search bounds, multipliers and the result register.
// Depends on rws_pkg.
module rws_datapath
    import rws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  item_t      item,
    input  logic       result_stall,
    output dp_status_t status,
    output logic       result_valid,
    output result_t    result
);

    logic [SUM_W-1:0]  mem [POP_MAX];
    logic [SUM_W-1:0]  rd_data_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] target_reg;
    logic [DRAW_W-1:0] draw_reg;

    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [SUM_W-1:0]  total_reg,  total_next;
    logic [IDX_W-1:0]  lo_reg,     lo_next;
    logic [IDX_W-1:0]  hi_reg,     hi_next;
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    logic [IDX_W:0]    mid_sum;
    logic [IDX_W-1:0]  mid;
    logic [SUM_W-1:0]  load_sum;
    logic              full;
    logic              empty;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[IDX_W:1];
    assign load_sum = total_reg + SUM_W'(item.fitness_value);
    assign full     = (count_reg == CNT_W'(POP_MAX));
    assign empty    = (count_reg == '0) || (total_reg == '0);

    // Report to the controller
    assign status.empty    = empty;
    assign status.done     = (lo_reg == hi_reg);
    assign status.out_free = !result_valid_reg || !result_stall;

    // Next values of control and search registers
    always_comb
    begin
        count_next        = count_reg;
        total_next        = total_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (cmd.clear)
        begin
            count_next = '0;
            total_next = '0;
        end
        if (cmd.load && !full)
        begin
            count_next = count_reg + CNT_W'(1);
            total_next = load_sum;
        end
        if (cmd.setup)
        begin
            lo_next = '0;
            hi_next = IDX_W'(count_reg - CNT_W'(1));
        end
        // Narrow the search: keep mid when it qualifies, else move past it
        if (cmd.step)
        begin
            if (prod_reg > target_reg)
                hi_next = mid;
            else
                lo_next = mid + IDX_W'(1);
        end

        // Drop the result once taken, load a new one on emit
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
        if (cmd.emit)
        begin
            result_valid_next         = 1'b1;
            result_next.empty_flag    = empty;
            result_next.selected_index = empty ? '0 : lo_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            total_reg        <= '0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            total_reg        <= total_next;
            lo_reg           <= lo_next;
            hi_reg           <= hi_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers and memory
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (cmd.load && !full)
            mem[count_reg[IDX_W-1:0]] <= load_sum;
        if (cmd.capture)
            draw_reg <= item.random_draw;
        if (cmd.setup)
            target_reg <= PROD_W'(draw_reg) * PROD_W'(total_reg);
        if (cmd.read)
            rd_data_reg <= mem[mid];
        if (cmd.mult)
            prod_reg <= PROD_W'(rd_data_reg) * PROD_W'(SCALE);
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(POP_MAX))
        else $error("member count beyond table size");

    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("search bounds crossed");

    a_empty_index: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.empty_flag |-> result_reg.selected_index == '0)
        else $error("empty result carries a nonzero index");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !result_valid_reg || !result_stall)
        else $error("result overwritten while stalled");
`endif

endmodule

[rtl/rws_ctrl.sv]
// Controller of the roulette wheel selector: sequences clear, load and the
// binary search of a draw. Depends on rws_pkg.
module rws_ctrl
    import rws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [1:0] item_cmd,
    input  dp_status_t status,
    output logic       item_stall,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   accept;

    assign accept = item_valid && !item_stall;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && item_cmd == CMD_DRAW)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.empty)
                    state_next = ST_EMIT;
                else
                    state_next = ST_LOOP;
            end
            ST_LOOP:
            begin
                if (status.done)
                    state_next = ST_EMIT;
                else
                    state_next = ST_READ;
            end
            ST_READ: state_next = ST_MULT;
            ST_MULT: state_next = ST_STEP;
            ST_STEP: state_next = ST_LOOP;
            ST_EMIT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall  = 1'b0;
                cmd.clear   = accept && (item_cmd == CMD_CLEAR);
                cmd.load    = accept && (item_cmd == CMD_LOAD);
                cmd.capture = accept && (item_cmd == CMD_DRAW);
            end
            ST_CHECK: cmd.setup = !status.empty;
            ST_LOOP:  ;
            ST_READ:  cmd.read = 1'b1;
            ST_MULT:  cmd.mult = 1'b1;
            ST_STEP:  cmd.step = 1'b1;
            ST_EMIT:  cmd.emit = status.out_free;
            default:  ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_emit_returns: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle after emit");

    a_draw_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_CHECK)
        else $error("draw accepted but search not started");

    a_step_after_mult: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> $past(cmd.mult))
        else $error("search step without a fresh product");
`endif

endmodule

[rtl/roulette_wheel_selector_unit.sv]
// Roulette wheel selector, top level: controller plus datapath.
// Clear, load and unused codes are taken in the idle state. A draw occupies the unit
// from its accept through a check, the binary search over the n loaded members and
// the emit; an empty table or zero total skips the search. Each search step reads
// the table, multiplies and narrows the bounds; a stalled result holds the emit.
// rst_n (async, active low) empties the table and drops any pending result.
module roulette_wheel_selector_unit
    import rws_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    rws_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_cmd   (item.cmd),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    rws_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .result_stall (result_stall),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[verif/rws_selection_check.sv]
// Selection checker for the roulette wheel selector unit.
// Watches both channels, predicts each draw's selection and compares results in order.
// Depends on rws_pkg for the item and result transaction types.
module rws_selection_check
    import rws_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      fail_count,
    output int      pending,
    output int      checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted table: prefix sums of loaded fitness values
    logic [SUM_W-1:0] fit_prefix [POP_MAX];
    logic [CNT_W-1:0] members;
    logic [SUM_W-1:0] fit_total;
    result_t          expected_picks [$];
    result_t          want;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    // Pick the lowest member whose scaled prefix sum beats p times the total;
    // fall back to the last member when none does
    function automatic result_t roulette_pick(input logic [DRAW_W-1:0] p);
        logic [PROD_W-1:0] threshold;
        result_t           pick;
        pick.empty_flag     = (members == '0) || (fit_total == '0);
        pick.selected_index = '0;
        if (!pick.empty_flag)
        begin
            threshold           = PROD_W'(p) * PROD_W'(fit_total);
            pick.selected_index = IDX_W'(members - 1'b1);
            for (int j = int'(members) - 1; j >= 0; j--)
            begin
                if (PROD_W'(SCALE) * PROD_W'(fit_prefix[j]) > threshold)
                    pick.selected_index = IDX_W'(j);
            end
        end
        return pick;
    endfunction

    // Compare the result transaction first: it always belongs to an older draw
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            members   = '0;
            fit_total = '0;
            expected_picks.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_picks.size() == 0)
                begin
                    $error("unexpected result: selected_index %0d empty_flag %0d",
                           result.selected_index, result.empty_flag);
                    fail_count++;
                end
                else
                begin
                    want = expected_picks.pop_front();
                    checked++;
                    if (result.selected_index !== want.selected_index)
                    begin
                        $error("selected_index: expected %0d, actual %0d",
                               want.selected_index, result.selected_index);
                        fail_count++;
                    end
                    if (result.empty_flag !== want.empty_flag)
                    begin
                        $error("empty_flag: expected %0d, actual %0d",
                               want.empty_flag, result.empty_flag);
                        fail_count++;
                    end
                end
            end

            // Advance the predicted table on each accepted item transaction
            if (item_valid && !item_stall)
            begin
                case (item.cmd)
                    CMD_CLEAR:
                    begin
                        members   = '0;
                        fit_total = '0;
                    end
                    CMD_LOAD:
                    begin
                        // drop loads into a full table
                        if (members < POP_MAX)
                        begin
                            fit_total                        = fit_total + item.fitness_value;
                            fit_prefix[members[IDX_W-1:0]]   = fit_total;
                            members                          = members + 1'b1;
                        end
                    end
                    CMD_DRAW:
                        expected_picks.push_back(roulette_pick(item.random_draw));
                    default:
                    begin
                    end
                endcase
            end
        end
        pending = expected_picks.size();
    end

endmodule

[verif/tb_top.sv]
// Top of the roulette wheel selector testbench: clock, reset, stimulus and verdict.
// Drives clears, loads and draws under three idling mixes and a long output hold.
// Depends on rws_pkg, roulette_wheel_selector_unit and rws_selection_check.
module tb_top
    import rws_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         PHASE_ITEMS = 430;
    localparam int         LONG_HOLD   = 300;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    int fail_count;
    int pending;
    int checked;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_left     = 0;

    int n_clear     = 0;
    int n_load      = 0;
    int n_full_load = 0;
    int n_draw      = 0;
    int n_unused    = 0;
    int useful      = 0;
    int tb_members  = 0;

    roulette_wheel_selector_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    rws_selection_check sel_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    // Free-running clock, 10 ns period
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on run length
    initial
    begin
        #4_000_000;
        $error("timeout: %0d selections still outstanding", pending);
        $display("== FAIL ==");
        $finish;
    end

    // Output side: random stall, or a long hold when requested
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
                result_stall <= (int'($urandom_range(99)) < recv_idle_pct);
        end
    end

    // Offer one item transaction and hold it until accepted
    task automatic offer(input logic [1:0] c, input logic [FIT_W-1:0] fit,
                         input logic [DRAW_W-1:0] p);
        @(negedge clk);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{cmd: c, fitness_value: fit, random_draw: p};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        case (c)
            CMD_CLEAR:
            begin
                n_clear++;
                useful++;
                tb_members = 0;
            end
            CMD_LOAD:
            begin
                if (tb_members < POP_MAX)
                begin
                    n_load++;
                    useful++;
                    tb_members++;
                end
                else
                    n_full_load++;
            end
            CMD_DRAW:
            begin
                n_draw++;
                useful++;
            end
            default:
                n_unused++;
        endcase
    endtask

    // Drop valid and wait until every predicted selection has come back
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        wait (pending == 0);
    endtask

    // Fitness mix: zeros, all ones, small weights, values below 2^17, full range
    function automatic logic [FIT_W-1:0] rand_fitness(input bit zero_only);
        int r;
        r = int'($urandom_range(9));
        if (zero_only)
            return '0;
        case (r)
            0:       return '0;
            1:       return '1;
            2, 3:    return FIT_W'($urandom_range(255));
            4, 5:    return FIT_W'($urandom_range(32'h0001_FFFF));
            default: return FIT_W'($urandom);
        endcase
    endfunction

    // Draw mix: mostly in range, with the ends and the out-of-range codes
    function automatic logic [DRAW_W-1:0] rand_draw();
        int r;
        r = int'($urandom_range(19));
        case (r)
            0:       return '0;
            1:       return DRAW_W'(999);
            2, 3:    return DRAW_W'($urandom_range(1023, 1000));
            default: return DRAW_W'($urandom_range(999));
        endcase
    endfunction

    // Mostly well-formed sequences: clear, a batch of loads, then several draws
    task automatic run_phase(input int target);
        int  start;
        int  n_mem;
        int  n_draws;
        int  r;
        bit  zero_only;
        start = useful;
        while (useful - start < target)
        begin
            if ($urandom_range(9) == 0)
            begin
                offer(2'($urandom_range(3)), FIT_W'($urandom), DRAW_W'($urandom));
                continue;
            end
            offer(CMD_CLEAR, FIT_W'($urandom), DRAW_W'($urandom));
            r = int'($urandom_range(99));
            if (r < 80)
                n_mem = int'($urandom_range(12, 1));
            else if (r < 95)
                n_mem = int'($urandom_range(63, 13));
            else
                n_mem = int'($urandom_range(70, 64));
            zero_only = ($urandom_range(19) == 0);
            for (int i = 0; i < n_mem; i++)
                offer(CMD_LOAD, rand_fitness(zero_only), DRAW_W'($urandom));
            n_draws = int'($urandom_range(8, 1));
            for (int i = 0; i < n_draws; i++)
                offer(CMD_DRAW, FIT_W'($urandom), rand_draw());
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, unused code, zero total, extreme fields
        send_idle_pct = 17;
        recv_idle_pct = 83;
        offer(CMD_DRAW,   '0,            '0);
        offer(CMD_UNUSED, '1,            '1);
        offer(CMD_LOAD,   '0,            '0);
        offer(CMD_LOAD,   '0,            '1);
        offer(CMD_DRAW,   '0,            DRAW_W'(500));
        offer(CMD_CLEAR,  '1,            '1);
        offer(CMD_LOAD,   '1,            '0);
        offer(CMD_LOAD,   32'h0000_0001, '0);
        offer(CMD_LOAD,   32'h0001_0000, '0);
        offer(CMD_LOAD,   32'hAAAA_AAAA, 10'h2AA);
        offer(CMD_LOAD,   32'h5555_5555, 10'h155);
        offer(CMD_DRAW,   '1,            '0);
        offer(CMD_DRAW,   '0,            DRAW_W'(999));
        offer(CMD_DRAW,   '0,            '1);
        offer(CMD_DRAW,   '0,            DRAW_W'(1000));
        offer(CMD_DRAW,   32'hAAAA_AAAA, 10'h2AA);
        offer(CMD_DRAW,   32'h5555_5555, 10'h155);
        offer(CMD_LOAD,   '0,            '0);
        offer(CMD_DRAW,   '0,            DRAW_W'(500));
        offer(CMD_CLEAR,  '0,            '0);
        offer(CMD_DRAW,   '0,            '0);

        // Random: sender rarely idle, receiver mostly stalled
        run_phase(PHASE_ITEMS);
        drain();

        // Random: sender mostly idle, receiver rarely stalled
        send_idle_pct = 83;
        recv_idle_pct = 17;
        run_phase(PHASE_ITEMS);
        drain();

        // Back-pressure: hold the output while draws keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        offer(CMD_CLEAR, '0, '0);
        for (int i = 0; i < 20; i++)
            offer(CMD_LOAD, rand_fitness(1'b0), DRAW_W'($urandom));
        hold_req = LONG_HOLD;
        for (int i = 0; i < 12; i++)
            offer(CMD_DRAW, FIT_W'($urandom), rand_draw());
        drain();

        // Random: no idling on either side
        run_phase(PHASE_ITEMS);
        drain();
        repeat (60) @(posedge clk);

        $display("Covered %0d clears, %0d loads, %0d loads into a full table,",
                 n_clear, n_load, n_full_load);
        $display("%0d draws, %0d unused codes; checked %0d selections over three idling mixes.",
                 n_draw, n_unused, checked);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
rtl/rws_pkg.sv
rtl/rws_datapath.sv
rtl/rws_ctrl.sv
rtl/roulette_wheel_selector_unit.sv
verif/rws_selection_check.sv
verif/tb_top.sv
